// ===== rtl/core/hbvt_pkg.sv =====
`default_nettype none

package hbvt_pkg;

   localparam int BUCKETS_DEF      = 64;
   localparam int BUCKET_DEPTH_DEF = 16;

   localparam int          HASH_W     = 64;
   localparam logic [63:0] HASH_SEED  = 64'd5381;
   localparam int          HASH_SHIFT = 5;

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 16;
   localparam int COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [7:0]         key_byte;
      logic               key_last;
      logic [VALUE_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  bucket_count;
      logic                last_result;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/hbvt_hash.sv =====
`default_nettype none

module hbvt_hash #(
   parameter int BUCKETS = hbvt_pkg::BUCKETS_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          take,
   input  wire logic [7:0]                                    key_byte,
   input  wire logic                                          key_last,
   output logic                                               bkt_valid,
   output logic [$clog2(BUCKETS > 1 ? BUCKETS : 2)-1:0]       bkt_index
);
   import hbvt_pkg::*;

   localparam int IDXW    = $clog2(BUCKETS > 1 ? BUCKETS : 2);
   localparam int DIGIT_W = 8;
   localparam int STEPS   = HASH_W / DIGIT_W;
   localparam int STEP_W  = $clog2(STEPS);
   localparam logic [IDXW:0]     BUCKET_NUM = (IDXW+1)'(BUCKETS);
   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(STEPS - 1);

   // one Horner step of the residue: (2r + b) mod BUCKETS, r already reduced
   function automatic logic [IDXW-1:0] dbl_mod(logic [IDXW-1:0] r, logic b);
      logic [IDXW:0] t;
      t = {r, b};
      if (t >= BUCKET_NUM)
         t = t - BUCKET_NUM;
      return t[IDXW-1:0];
   endfunction

   function automatic logic [IDXW-1:0] fold_digit(logic [IDXW-1:0] r,
                                                   logic [DIGIT_W-1:0] d);
      logic [IDXW-1:0] t;
      t = r;
      for (int i = DIGIT_W - 1; i >= 0; i--)
         t = dbl_mod(t, d[i]);
      return t;
   endfunction

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              ended_ff, ended_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDXW-1:0]   res_ff, res_in;
   logic [HASH_W-1:0] hash_next;

   // hash * 33 + byte, wrapping at 64 bits
   assign hash_next = (hash_ff << HASH_SHIFT) + hash_ff + HASH_W'(key_byte);

   always_comb begin
      hash_in  = hash_ff;
      ended_in = ended_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      res_in   = res_ff;
      if (busy_ff) begin
         // reduce the finished hash, one byte per cycle from the top
         res_in  = fold_digit(res_ff, hash_ff[HASH_W-1 -: DIGIT_W]);
         step_in = step_ff + STEP_W'(1);
         hash_in = hash_ff << DIGIT_W;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            hash_in = HASH_SEED;
         end
      end else if (take) begin
         if (!ended_ff && key_byte != 8'd0)
            hash_in = hash_next;
         if (key_byte == 8'd0)
            ended_in = 1'b1;
         if (key_last) begin
            ended_in = 1'b0;
            busy_in  = 1'b1;
            step_in  = '0;
            res_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_SEED;
         ended_ff <= 1'b0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         hash_ff  <= hash_in;
         ended_ff <= ended_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      res_ff <= res_in;
   end

   assign bkt_valid = done_ff;
   assign bkt_index = res_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hbvt_engine.sv =====
`default_nettype none

module hbvt_engine #(
   parameter int BUCKETS      = hbvt_pkg::BUCKETS_DEF,
   parameter int BUCKET_DEPTH = hbvt_pkg::BUCKET_DEPTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     take_last,
   input  wire logic [hbvt_pkg::FUNC_W-1:0]              func,
   input  wire logic [hbvt_pkg::VALUE_W-1:0]             entry_value,
   input  wire logic                                     bkt_valid,
   input  wire logic [$clog2(BUCKETS > 1 ? BUCKETS : 2)-1:0] bkt_index,
   input  wire logic                                     out_free,
   output logic                                          ready,
   output logic                                          rsp_load,
   output hbvt_pkg::rsp_type                             rsp_out
);
   import hbvt_pkg::*;

   localparam int IDXW    = $clog2(BUCKETS > 1 ? BUCKETS : 2);
   localparam int CNTW    = $clog2(BUCKET_DEPTH + 1);
   localparam int ENTRIES = BUCKETS * BUCKET_DEPTH;
   localparam int EADRW   = $clog2(ENTRIES > 1 ? ENTRIES : 2);
   localparam logic [CNTW-1:0]  DEPTH_CNT = CNTW'(BUCKET_DEPTH);
   localparam logic [EADRW-1:0] DEPTH_ADR = EADRW'(BUCKET_DEPTH);
   localparam logic [IDXW-1:0]  LAST_BKT  = IDXW'(BUCKETS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_DISPATCH,
      ST_GET_EMIT,
      ST_REM_CHK,
      ST_REM_MOVE
   } state_type;

   function automatic logic [COUNT_W-1:0] to_count(logic [CNTW-1:0] c);
      logic [CNTW+COUNT_W-1:0] w;
      w = (CNTW+COUNT_W)'(c);
      return w[COUNT_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [IDXW-1:0]      bkt_ff, bkt_in;
   logic [EADRW-1:0]     base_ff, base_in;
   logic [CNTW-1:0]      idx_ff, idx_in;
   logic [IDXW-1:0]      clr_ff, clr_in;

   logic [CNTW-1:0]      fill_mem [BUCKETS];
   logic [CNTW-1:0]      fill_rd_ff;
   logic                 fill_we, fill_re;
   logic [IDXW-1:0]      fill_wa;
   logic [CNTW-1:0]      fill_wd;

   logic [VALUE_W-1:0]   ent_mem [ENTRIES];
   logic [VALUE_W-1:0]   ent_rd_ff;
   logic                 ent_we, ent_re;
   logic [EADRW-1:0]     ent_wa, ent_ra;
   logic [VALUE_W-1:0]   ent_wd;

   logic [CNTW-1:0]      idx_nx;
   logic                 idx_end;

   assign idx_nx  = idx_ff + CNTW'(1);
   assign idx_end = (idx_nx == fill_rd_ff);

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      value_in = value_ff;
      bkt_in   = bkt_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      clr_in   = clr_ff;
      fill_we  = 1'b0;
      fill_re  = 1'b0;
      fill_wa  = bkt_ff;
      fill_wd  = fill_rd_ff;
      ent_we   = 1'b0;
      ent_re   = 1'b0;
      ent_wa   = base_ff + EADRW'(idx_ff);
      ent_ra   = base_ff + EADRW'(idx_ff);
      ent_wd   = value_ff;
      rsp_load = 1'b0;
      rsp_out.status       = STAT_OK;
      rsp_out.read_value   = '0;
      rsp_out.bucket_count = to_count(fill_rd_ff);
      rsp_out.last_result  = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_ff;
            fill_wd = '0;
            clr_in  = clr_ff + IDXW'(1);
            if (clr_ff == LAST_BKT)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take_last) begin
               func_in  = func;
               value_in = entry_value;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (bkt_valid) begin
               fill_re  = 1'b1;
               bkt_in   = bkt_index;
               base_in  = EADRW'(bkt_index) * DEPTH_ADR;
               idx_in   = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (func_ff)
               FUNC_ADD: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                     if (fill_rd_ff >= DEPTH_CNT) begin
                        rsp_out.status = STAT_FULL;
                     end else begin
                        ent_we  = 1'b1;
                        ent_wa  = base_ff + EADRW'(fill_rd_ff);
                        fill_we = 1'b1;
                        fill_wd = fill_rd_ff + CNTW'(1);
                        rsp_out.bucket_count = to_count(fill_rd_ff + CNTW'(1));
                     end
                  end
               end
               FUNC_REMOVE: begin
                  if (fill_rd_ff == '0) begin
                     if (out_free) begin
                        rsp_load       = 1'b1;
                        rsp_out.status = STAT_NOT_FOUND;
                        state_in       = ST_IDLE;
                     end
                  end else begin
                     ent_re   = 1'b1;
                     state_in = ST_REM_CHK;
                  end
               end
               FUNC_GET: begin
                  if (fill_rd_ff == '0) begin
                     if (out_free) begin
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     ent_re   = 1'b1;
                     state_in = ST_GET_EMIT;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_GET_EMIT: begin
            // next read goes out in the cycle its slot is freed
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_out.read_value  = ent_rd_ff;
               rsp_out.last_result = idx_end;
               if (idx_end) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_nx;
                  ent_re = 1'b1;
                  ent_ra = base_ff + EADRW'(idx_nx);
               end
            end
         end
         ST_REM_CHK: begin
            if (ent_rd_ff == value_ff) begin
               ent_re   = 1'b1;
               ent_ra   = base_ff + EADRW'(fill_rd_ff - CNTW'(1));
               state_in = ST_REM_MOVE;
            end else if (idx_end) begin
               if (out_free) begin
                  rsp_load       = 1'b1;
                  rsp_out.status = STAT_NOT_FOUND;
                  state_in       = ST_IDLE;
               end
            end else begin
               idx_in = idx_nx;
               ent_re = 1'b1;
               ent_ra = base_ff + EADRW'(idx_nx);
            end
         end
         ST_REM_MOVE: begin
            // final entry of the bucket fills the matched slot
            if (out_free) begin
               ent_we   = 1'b1;
               ent_wd   = ent_rd_ff;
               fill_we  = 1'b1;
               fill_wd  = fill_rd_ff - CNTW'(1);
               rsp_load = 1'b1;
               rsp_out.bucket_count = to_count(fill_rd_ff - CNTW'(1));
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      func_ff  <= func_in;
      value_ff <= value_in;
      bkt_ff   <= bkt_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we)
         fill_mem[fill_wa] <= fill_wd;
      if (fill_re)
         fill_rd_ff <= fill_mem[bkt_index];
   end

   always_ff @(posedge clock) begin
      if (ent_we)
         ent_mem[ent_wa] <= ent_wd;
      if (ent_re)
         ent_rd_ff <= ent_mem[ent_ra];
   end

   assign ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/hashed_bucket_value_table.sv =====
// Hashed bucket table of 16-bit values, keyed by byte strings.
// req channel: one key byte per transfer, with func and entry_value taken on
// the transfer that has key_last set. Bytes that are not last are taken one per
// cycle while req_stall is low and give no result; a zero byte ends hashing
// for that key. At key end the 64-bit hash is reduced modulo BUCKETS, 8 bits
// per cycle, then the bucket fill count is read from its memory. rsp_valid
// rises once the result is loaded into the output register; a get of a
// filled bucket first reads its first stored value.
// rsp channel: add, remove, an empty get and an unknown func give one result;
// get gives one result per stored value, one per cycle while the output is
// not stalled, last_result on the final one. Remove scans the bucket one
// entry per cycle, then moves the final entry into the matched slot.
// req_stall stays high from the last byte until the final result is loaded.
// After reset the fill count memory is cleared, one bucket per cycle, with
// req_stall high. Stored values are not cleared.
// A stalled result holds in the output register; the block waits on it
// without dropping or repeating anything.
`default_nettype none

module hashed_bucket_value_table #(
   parameter int BUCKETS      = hbvt_pkg::BUCKETS_DEF,
   parameter int BUCKET_DEPTH = hbvt_pkg::BUCKET_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hbvt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hbvt_pkg::rsp_type      rsp_data
);
   import hbvt_pkg::*;

   localparam int IDXW = $clog2(BUCKETS > 1 ? BUCKETS : 2);

   logic            take;
   logic            ready;
   logic            bkt_valid;
   logic [IDXW-1:0] bkt_index;
   logic            out_free;
   logic            rsp_load;
   rsp_type         rsp_out;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   assign req_stall = !ready;
   assign take      = req_valid && ready;

   hbvt_hash #(
      .BUCKETS(BUCKETS)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .key_byte  (req_data.key_byte),
      .key_last  (req_data.key_last),
      .bkt_valid (bkt_valid),
      .bkt_index (bkt_index)
   );

   hbvt_engine #(
      .BUCKETS      (BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .take_last   (take && req_data.key_last),
      .func        (req_data.func),
      .entry_value (req_data.entry_value),
      .bkt_valid   (bkt_valid),
      .bkt_index   (bkt_index),
      .out_free    (out_free),
      .ready       (ready),
      .rsp_load    (rsp_load),
      .rsp_out     (rsp_out)
   );

   // output register frees up in the same cycle its transfer completes
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_out;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
import hbvt_pkg::*;

typedef logic [7:0] key_t[$];

class bucket_scoreboard;
   logic [63:0]        hash;
   bit                 hash_done;
   logic [COUNT_W-1:0] fill_count[BUCKETS_DEF];
   logic [VALUE_W-1:0] slot_mem[BUCKETS_DEF][BUCKET_DEPTH_DEF];
   rsp_type            pending_q[$];
   int                 errors;

   function new();
      hash      = HASH_SEED;
      hash_done = 1'b0;
      errors    = 0;
      foreach (fill_count[b]) fill_count[b] = '0;
   endfunction

   function int outstanding();
      return pending_q.size();
   endfunction

   function void queue_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] val,
                              logic [COUNT_W-1:0] cnt, logic last);
      rsp_type r;
      r.status       = st;
      r.read_value   = val;
      r.bucket_count = cnt;
      r.last_result  = last;
      pending_q.push_back(r);
   endfunction

   // called on every accepted req transfer
   function void note_input(req_type item);
      int                  b;
      int                  fill;
      logic [STATUS_W-1:0] st;
      if (!hash_done) begin
         if (item.key_byte == 8'd0)
            hash_done = 1'b1;
         else
            hash = (hash << HASH_SHIFT) + hash + 64'(item.key_byte);
      end
      if (!item.key_last)
         return;
      b         = int'(hash % BUCKETS_DEF);
      hash      = HASH_SEED;
      hash_done = 1'b0;
      fill      = fill_count[b];
      case (item.func)
         FUNC_ADD: begin
            if (fill >= BUCKET_DEPTH_DEF) begin
               queue_result(STAT_FULL, '0, COUNT_W'(fill), 1'b1);
            end else begin
               slot_mem[b][fill] = item.entry_value;
               fill++;
               fill_count[b] = COUNT_W'(fill);
               queue_result(STAT_OK, '0, COUNT_W'(fill), 1'b1);
            end
         end
         FUNC_REMOVE: begin
            st = STAT_NOT_FOUND;
            for (int i = 0; i < fill; i++) begin
               if (slot_mem[b][i] == item.entry_value) begin
                  // final entry fills the hole
                  fill--;
                  slot_mem[b][i] = slot_mem[b][fill];
                  fill_count[b]  = COUNT_W'(fill);
                  st = STAT_OK;
                  break;
               end
            end
            queue_result(st, '0, COUNT_W'(fill), 1'b1);
         end
         FUNC_GET: begin
            if (fill == 0) begin
               queue_result(STAT_OK, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < fill; i++)
                  queue_result(STAT_OK, slot_mem[b][i], COUNT_W'(fill), i == fill - 1);
            end
         end
         default: begin
            queue_result(STAT_OK, '0, COUNT_W'(fill), 1'b1);
         end
      endcase
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %p", $time, got);
         errors++;
         return;
      end
      want = pending_q.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("bucket_count", 16'(want.bucket_count), 16'(got.bucket_count));
      compare_field("last_result", 16'(want.last_result), 16'(got.last_result));
   endfunction
endclass

module tb_top;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bucket_scoreboard sb = new();

   int   snd_idle_pct = 0;
   int   rcv_idle_pct = 0;
   int   hold_cycles  = 0;
   int   items_sent   = 0;
   key_t key_pool[4];

   hashed_bucket_value_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            $display("%0t: rsp_valid unknown, expected 0 or 1, actual %b", $time, rsp_valid);
            sb.errors++;
         end else if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_byte(req_type item);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_input(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_key(key_t key, logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
      req_type item;
      foreach (key[i]) begin
         item.key_byte = key[i];
         item.key_last = (i == key.size() - 1);
         if (item.key_last) begin
            item.func        = func;
            item.entry_value = value;
         end else begin
            // ignored on bytes that are not last
            item.func        = FUNC_W'($urandom_range(3));
            item.entry_value = VALUE_W'($urandom);
         end
         send_byte(item);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0)
         @(negedge clock);
   endtask

   function automatic key_t random_key(int max_len);
      key_t k;
      int   len;
      len = $urandom_range(max_len, 1);
      repeat (len) begin
         if ($urandom_range(99) < 10)
            k.push_back(8'd0);
         else
            k.push_back(8'($urandom_range(255)));
      end
      return k;
   endfunction

   task automatic random_op();
      key_t               key;
      logic [VALUE_W-1:0] value;
      int                 r;
      r = $urandom_range(99);
      if ($urandom_range(99) < 80)
         key = key_pool[$urandom_range(3)];
      else
         key = random_key(10);
      if ($urandom_range(99) < 65)
         value = VALUE_W'($urandom_range(15));
      else
         value = VALUE_W'($urandom_range(65535));
      if (r < 4) begin
         // run one bucket into full, then read it all back
         repeat (BUCKET_DEPTH_DEF + 2)
            send_key(key, FUNC_ADD, VALUE_W'($urandom));
         send_key(key, FUNC_GET, value);
      end else if (r < 46) begin
         send_key(key, FUNC_ADD, value);
      end else if (r < 70) begin
         send_key(key, FUNC_REMOVE, value);
      end else if (r < 95) begin
         send_key(key, FUNC_GET, value);
      end else begin
         send_key(key, FUNC_UNUSED, value);
      end
   endtask

   initial begin
      int target;
      foreach (key_pool[i])
         key_pool[i] = random_key(5);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      snd_idle_pct = 27;
      rcv_idle_pct = 66;
      send_key('{8'h41}, FUNC_ADD, 16'h0000);
      send_key('{8'h41}, FUNC_ADD, 16'hFFFF);
      send_key('{8'h41}, FUNC_GET, 16'h0000);
      send_key('{8'h41}, FUNC_REMOVE, 16'h1234);
      send_key('{8'h41}, FUNC_REMOVE, 16'h0000);
      send_key('{8'h41}, FUNC_GET, 16'h0000);
      send_key('{8'h41}, FUNC_REMOVE, 16'hFFFF);
      send_key('{8'h41}, FUNC_GET, 16'hFFFF);
      // zero byte stops hashing, so this lands in the same bucket
      send_key('{8'h41, 8'h00, 8'h42}, FUNC_ADD, 16'hA5A5);
      send_key('{8'h00}, FUNC_GET, 16'h0000);
      send_key('{8'hFF}, FUNC_UNUSED, 16'h5A5A);
      send_key('{8'h41}, FUNC_UNUSED, 16'h0000);
      send_key('{8'h41}, FUNC_GET, 16'h0000);
      wait_drained();

      target = items_sent + 30;
      while (items_sent < target)
         random_op();
      hold_cycles = 400;
      target = items_sent + 60;
      while (items_sent < target)
         random_op();
      wait_drained();

      snd_idle_pct = 66;
      rcv_idle_pct = 27;
      target = items_sent + 90;
      while (items_sent < target)
         random_op();
      wait_drained();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      target = items_sent + 90;
      while (items_sent < target)
         random_op();

      wait_drained();
      repeat (40) @(negedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/hbvt_pkg.sv
rtl/core/hbvt_hash.sv
rtl/core/hbvt_engine.sv
rtl/core/hashed_bucket_value_table.sv
tb/tb_top.sv
